// ----- hdl/complex_integer_alu_core_macros.svh -----
// Assertion macros for the complex integer arithmetic unit
`ifndef COMPLEX_INTEGER_ALU_CORE_MACROS_SVH
`define COMPLEX_INTEGER_ALU_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define CIA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define CIA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define CIA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define CIA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hdl/cia_pkg.sv -----
// Shared types and constants for the complex integer arithmetic unit
package cia_pkg;
	localparam int OPERAND_WIDTH = 16;
	localparam logic [2:0] OP_ADD  = 3'd0;
	localparam logic [2:0] OP_SUB  = 3'd1;
	localparam logic [2:0] OP_MUL  = 3'd2;
	localparam logic [2:0] OP_CDIV = 3'd3;
	localparam logic [2:0] OP_CONJ = 3'd4;
	localparam logic [2:0] OP_RDIV = 3'd5;
endpackage

// ----- hdl/cia_divider.sv -----
// Pipelined restoring divider, one quotient bit per stage, truncation toward zero
module cia_divider #(
	parameter int NW = 34,
	parameter int DW = 33,
	parameter int TW = 8
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic signed [NW-1:0] num,
	input  logic [DW-1:0]        den,
	input  logic [TW-1:0]        tag_in,
	output logic signed [NW-1:0] quo,
	output logic [TW-1:0]        tag_out
);
	// den is a positive magnitude; sign handled on numerator only
	logic [NW-1:0]   q_s [0:NW];
	logic [DW:0]     r_s [0:NW];
	logic [DW-1:0]   d_s [0:NW];
	logic            n_s [0:NW];
	logic [TW-1:0]   t_s [0:NW];

	always_comb begin
		q_s[0] = num[NW-1] ? NW'(-num) : NW'(num);
		r_s[0] = '0;
		d_s[0] = den;
		n_s[0] = num[NW-1];
		t_s[0] = tag_in;
	end

	for (genvar i = 0; i < NW; i++) begin : g_st
		logic [DW:0] sh;
		logic [DW:0] df;
		always_comb begin
			sh = {r_s[i][DW-1:0], q_s[i][NW-1]};
			df = sh - {1'b0, d_s[i]};
		end
		always_ff @(posedge clk) begin
			if (en) begin
				q_s[i+1] <= {q_s[i][NW-2:0], ~df[DW]};
				r_s[i+1] <= df[DW] ? sh : df;
				d_s[i+1] <= d_s[i];
				n_s[i+1] <= n_s[i];
				t_s[i+1] <= t_s[i];
			end
		end
	end

	assign quo = n_s[NW] ? -$signed(q_s[NW]) : $signed(q_s[NW]);
	assign tag_out = t_s[NW];
endmodule

// ----- hdl/cia_front.sv -----
// Operand products and numerator/denominator formation, two registered stages
module cia_front #(
	parameter int OW = cia_pkg::OPERAND_WIDTH
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [2:0]            op,
	input  logic signed [OW-1:0]  ar, ai, br, bi,
	output logic [2:0]            op_o,
	output logic signed [2*OW+1:0] x_o, y_o,
	output logic [2*OW:0]         den_o
);
	localparam int PW = 2*OW;
	logic [2:0] op_s1;
	logic signed [PW-1:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1, p_bb_s1, p_cc_s1;
	logic signed [OW-1:0] ar_s1, ai_s1, br_s1, bi_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= op;
			p_rr_s1 <= ar * br;
			p_ii_s1 <= ai * bi;
			p_ri_s1 <= ar * bi;
			p_ir_s1 <= ai * br;
			p_bb_s1 <= br * br;
			p_cc_s1 <= bi * bi;
			ar_s1 <= ar; ai_s1 <= ai; br_s1 <= br; bi_s1 <= bi;
		end
	end

	logic signed [PW+1:0] x, y;
	logic [PW:0] den;
	always_comb begin
		x = '0;
		y = '0;
		den = (PW+1)'(p_bb_s1) + (PW+1)'(p_cc_s1);
		case (op_s1)
			cia_pkg::OP_ADD: begin
				x = (PW+2)'(ar_s1) + (PW+2)'(br_s1);
				y = (PW+2)'(ai_s1) + (PW+2)'(bi_s1);
			end
			cia_pkg::OP_SUB: begin
				x = (PW+2)'(ar_s1) - (PW+2)'(br_s1);
				y = (PW+2)'(ai_s1) - (PW+2)'(bi_s1);
			end
			cia_pkg::OP_MUL: begin
				x = (PW+2)'(p_rr_s1) - (PW+2)'(p_ii_s1);
				y = (PW+2)'(p_ri_s1) + (PW+2)'(p_ir_s1);
			end
			cia_pkg::OP_CDIV: begin
				x = (PW+2)'(p_rr_s1) + (PW+2)'(p_ii_s1);
				y = (PW+2)'(p_ir_s1) - (PW+2)'(p_ri_s1);
			end
			cia_pkg::OP_CONJ: begin
				x = (PW+2)'(ar_s1);
				y = -(PW+2)'(ai_s1);
			end
			cia_pkg::OP_RDIV: begin
				x = (PW+2)'(ar_s1);
				y = (PW+2)'(ai_s1);
				den = br_s1[OW-1] ? (PW+1)'(-(PW+1)'(br_s1)) : (PW+1)'(br_s1);
			end
			default: ;
		endcase
	end

	// sign of real divisor goes into the numerators
	always_ff @(posedge clk) begin
		if (en) begin
			op_o <= op_s1;
			den_o <= den;
			if (op_s1 == cia_pkg::OP_RDIV && br_s1[OW-1]) begin
				x_o <= -x;
				y_o <= -y;
			end else begin
				x_o <= x;
				y_o <= y;
			end
		end
	end
endmodule

// ----- hdl/complex_integer_alu_core.sv -----
// From accepted input to result offered: front stages, divider pipeline, output register.
// Throughput: one item per cycle when not stalled, set by the one-bit-per-stage divider.
// The pipeline advances as one and halts on a stalled valid output, with no bubbles lost.
// Reset: arst_n clears all stage valid bits asynchronously; data registers are not reset.
`include "complex_integer_alu_core_macros.svh"
module complex_integer_alu_core #(
	parameter int OPERAND_WIDTH = cia_pkg::OPERAND_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [2:0]                     req_type,
	input  logic signed [OPERAND_WIDTH-1:0] a_re,
	input  logic signed [OPERAND_WIDTH-1:0] a_im,
	input  logic signed [OPERAND_WIDTH-1:0] b_re,
	input  logic signed [OPERAND_WIDTH-1:0] b_im,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic signed [2*OPERAND_WIDTH:0] res_re,
	output logic signed [2*OPERAND_WIDTH:0] res_im,
	output logic                           div_zero
);
	localparam int RW = 2*OPERAND_WIDTH + 1;
	localparam int NW = RW + 1;
	localparam int LAT = NW + 3;

	logic en;
	logic [LAT-1:0] vld_q;
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end

	logic [2:0] op_f;
	logic signed [NW-1:0] x_f, y_f;
	logic [RW-1:0] den_f;
	cia_front #(.OW(OPERAND_WIDTH)) u_front (
		.clk(clk), .en(en), .op(req_type), .ar(a_re), .ai(a_im), .br(b_re), .bi(b_im),
		.op_o(op_f), .x_o(x_f), .y_o(y_f), .den_o(den_f)
	);

	// zero divisor: divide by 1 and mask afterwards
	logic [RW-1:0] den_d;
	assign den_d = (den_f == '0) ? RW'(1) : den_f;
	logic [3:0] tag_i, tag_o;
	assign tag_i = {op_f, den_f == '0};

	logic signed [NW-1:0] qx, qy;
	logic [3:0] tag_im;
	cia_divider #(.NW(NW), .DW(RW), .TW(4)) u_div_re (
		.clk(clk), .en(en), .num(x_f), .den(den_d),
		.tag_in(tag_i), .quo(qx), .tag_out(tag_o)
	);
	cia_divider #(.NW(NW), .DW(RW), .TW(4)) u_div_im (
		.clk(clk), .en(en), .num(y_f), .den(den_d),
		.tag_in(tag_i), .quo(qy), .tag_out(tag_im)
	);

	logic [2:0] op_o;
	logic is_div, dz;
	logic signed [NW-1:0] xd_q [0:NW-1];
	logic signed [NW-1:0] yd_q [0:NW-1];
	always_ff @(posedge clk) begin
		if (en) begin
			xd_q[0] <= x_f;
			yd_q[0] <= y_f;
			for (int i = 1; i < NW; i++) begin
				xd_q[i] <= xd_q[i-1];
				yd_q[i] <= yd_q[i-1];
			end
		end
	end

	always_comb begin
		op_o = tag_o[3:1];
		is_div = (op_o == cia_pkg::OP_CDIV) || (op_o == cia_pkg::OP_RDIV);
		dz = is_div && tag_o[0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_zero <= dz;
			if (dz) begin
				res_re <= '0;
				res_im <= '0;
			end else if (is_div) begin
				res_re <= RW'(qx);
				res_im <= RW'(qy);
			end else begin
				res_re <= RW'(xd_q[NW-1]);
				res_im <= RW'(yd_q[NW-1]);
			end
		end
	end
	assign out_valid = vld_q[LAT-1];

	`CIA_ASSERT_IMPL(a_nostall_busy, clk, arst_n, !out_valid, !in_stall)
	`CIA_ASSERT_IMPL(a_dz_zero, clk, arst_n, out_valid && div_zero, res_re == '0 && res_im == '0)
	`CIA_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(res_re))
	`CIA_ASSERT_IMPL(a_tag_match, clk, arst_n, vld_q[LAT-2], tag_im == tag_o)
endmodule
